// ----- hw/rtl/tons_pkg.sv -----
package tons_pkg;

  localparam int TableDepth = 256;
  localparam int IdxW       = $clog2(TableDepth);
  localparam int CntW       = IdxW + 1;

  typedef enum logic [1:0] {
    FN_INSERT = 2'd0,
    FN_QUERY  = 2'd1,
    FN_READ   = 2'd2,
    FN_NONE   = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    OC_OK      = 2'd0,
    OC_FULL    = 2'd1,
    OC_EMPTY   = 2'd2,
    OC_BAD_IDX = 2'd3
  } outcome_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_INS_RD,
    S_INS_EV,
    S_QRY_RD,
    S_QRY_EV,
    S_RD_EV,
    S_DONE
  } state_e;

  typedef enum logic [1:0] {
    RD_HOLE,
    RD_PTR,
    RD_IDX
  } rd_sel_e;

  typedef enum logic [1:0] {
    RK_PLAIN,
    RK_QUERY,
    RK_ENTRY
  } res_kind_e;

  // first member sits in the top bits
  typedef struct packed {
    logic [3:0]  instr;
    logic [6:0]  vel;
    logic [6:0]  key;
    logic [7:0]  status;
    logic [15:0] tick;
    logic [3:0]  beat;
    logic [8:0]  bar;
  } note_t;

  localparam int NoteW = $bits(note_t);

  typedef struct packed {
    logic [7:0]  entry_index;
    logic [15:0] end_tick;
    logic [8:0]  end_bar;
    note_t       note;
  } req_t;

  typedef struct packed {
    note_t      entry;
    logic [8:0] match_count;
    logic [7:0] first_index;
  } res_t;

  typedef struct packed {
    logic      load;
    logic      ptr_top;
    logic      ptr_clr;
    logic      ptr_dec;
    logic      ptr_inc;
    rd_sel_e   rd_sel;
    logic      wr_move;
    logic      wr_new;
    logic      cnt_inc;
    logic      acc;
    logic      res_load;
    res_kind_e res_kind;
    outcome_e  res_outcome;
    logic      out_load;
  } cmd_t;

  typedef struct packed {
    func_e func;
    logic  full;
    logic  ptr_zero;
    logic  ptr_at_cnt;
    logic  brk;
    logic  qry_bad;
    logic  idx_bad;
    logic  out_free;
  } sts_t;

endpackage

// ----- hw/rtl/tons_ram.sv -----
module tons_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- hw/rtl/tons_ctrl.sv -----
module tons_ctrl import tons_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_valid_i,
  output logic s_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    cmd_o.rd_sel = RD_PTR;
    cmd_o.res_kind = RK_PLAIN;
    cmd_o.res_outcome = OC_OK;
    s_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          cmd_o.load = 1'b1;
          state_d = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (sts_i.func)
          FN_INSERT: begin
            if (sts_i.full) begin
              cmd_o.res_load = 1'b1;
              cmd_o.res_outcome = OC_FULL;
              state_d = S_DONE;
            end else begin
              cmd_o.ptr_top = 1'b1;
              state_d = S_INS_RD;
            end
          end
          FN_QUERY: begin
            if (sts_i.qry_bad) begin
              cmd_o.res_load = 1'b1;
              cmd_o.res_outcome = OC_EMPTY;
              state_d = S_DONE;
            end else begin
              cmd_o.ptr_clr = 1'b1;
              state_d = S_QRY_RD;
            end
          end
          FN_READ: begin
            if (sts_i.idx_bad) begin
              cmd_o.res_load = 1'b1;
              cmd_o.res_outcome = OC_BAD_IDX;
              state_d = S_DONE;
            end else begin
              cmd_o.rd_sel = RD_IDX;
              state_d = S_RD_EV;
            end
          end
          default: begin
            cmd_o.res_load = 1'b1;
            state_d = S_DONE;
          end
        endcase
      end
      S_INS_RD: begin
        cmd_o.rd_sel = RD_HOLE;
        if (sts_i.ptr_zero) begin
          cmd_o.wr_new = 1'b1;
          cmd_o.cnt_inc = 1'b1;
          cmd_o.res_load = 1'b1;
          state_d = S_DONE;
        end else begin
          state_d = S_INS_EV;
        end
      end
      S_INS_EV: begin
        if (sts_i.brk) begin
          cmd_o.wr_move = 1'b1;
          cmd_o.ptr_dec = 1'b1;
          state_d = S_INS_RD;
        end else begin
          cmd_o.wr_new = 1'b1;
          cmd_o.cnt_inc = 1'b1;
          cmd_o.res_load = 1'b1;
          state_d = S_DONE;
        end
      end
      S_QRY_RD: begin
        if (sts_i.ptr_at_cnt) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_kind = RK_QUERY;
          state_d = S_DONE;
        end else begin
          state_d = S_QRY_EV;
        end
      end
      S_QRY_EV: begin
        cmd_o.acc = 1'b1;
        cmd_o.ptr_inc = 1'b1;
        state_d = S_QRY_RD;
      end
      S_RD_EV: begin
        cmd_o.res_load = 1'b1;
        cmd_o.res_kind = RK_ENTRY;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

// ----- hw/rtl/tons_dp.sv -----
module tons_dp import tons_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  output sts_t        sts_o,
  input  logic [87:0] req_data_i,
  input  logic [1:0]  req_func_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [71:0] out_data_o,
  output logic [1:0]  out_user_o
);

  req_t            req_q;
  func_e           func_q;
  logic [CntW-1:0] count_q, ptr_q, first_q, last_q;
  res_t            res_q, res_d, out_data_q;
  outcome_e        res_oc_q, res_oc_d, out_oc_q;
  logic            out_valid_q;
  note_t           rd_note;
  logic [NoteW-1:0] rdata, wdata;
  logic [IdxW-1:0] raddr;
  logic [24:0]     new_key, ent_key, start_key, end_key;
  logic [CntW-1:0] span;

  tons_ram #(.Width(NoteW), .Depth(TableDepth)) u_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.wr_move | cmd_i.wr_new),
    .waddr_i(ptr_q[IdxW-1:0]),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign rd_note   = note_t'(rdata);
  assign wdata     = cmd_i.wr_move ? rdata : req_q.note;
  assign new_key   = {req_q.note.bar, req_q.note.tick};
  assign start_key = new_key;
  assign end_key   = {req_q.end_bar, req_q.end_tick};
  assign ent_key   = {rd_note.bar, rd_note.tick};
  assign span      = last_q - first_q;

  always_comb begin
    case (cmd_i.rd_sel)
      RD_HOLE: raddr = ptr_q[IdxW-1:0] - IdxW'(1);
      RD_IDX:  raddr = IdxW'(req_q.entry_index);
      default: raddr = ptr_q[IdxW-1:0];
    endcase
  end

  always_comb begin
    sts_o.func       = func_q;
    sts_o.full       = (count_q == CntW'(TableDepth));
    sts_o.ptr_zero   = (ptr_q == '0);
    sts_o.ptr_at_cnt = (ptr_q == count_q);
    sts_o.brk        = (ent_key > new_key) ||
                       ((ent_key == new_key) && (rd_note.status <= req_q.note.status));
    sts_o.qry_bad    = (end_key <= start_key);
    sts_o.idx_bad    = (CntW'(req_q.entry_index) >= count_q);
    sts_o.out_free   = !out_valid_q || out_ready_i;
  end

  always_comb begin
    res_d    = '0;
    res_oc_d = cmd_i.res_outcome;
    case (cmd_i.res_kind)
      RK_QUERY: begin
        if (last_q <= first_q) begin
          res_oc_d = OC_EMPTY;
        end else begin
          res_d.first_index = first_q[7:0];
          res_d.match_count = span[8:0];
        end
      end
      RK_ENTRY: res_d.entry = rd_note;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.cnt_inc) begin
        count_q <= count_q + 1'b1;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q  <= req_t'(req_data_i);
      func_q <= func_e'(req_func_i);
    end
    if (cmd_i.ptr_top) begin
      ptr_q <= count_q;
    end else if (cmd_i.ptr_clr) begin
      ptr_q <= '0;
    end else if (cmd_i.ptr_dec) begin
      ptr_q <= ptr_q - 1'b1;
    end else if (cmd_i.ptr_inc) begin
      ptr_q <= ptr_q + 1'b1;
    end
    if (cmd_i.ptr_clr) begin
      first_q <= '0;
      last_q  <= '0;
    end else if (cmd_i.acc) begin
      if (ent_key < start_key) first_q <= first_q + 1'b1;
      if (ent_key < end_key) last_q <= last_q + 1'b1;
    end
    if (cmd_i.res_load) begin
      res_q    <= res_d;
      res_oc_q <= res_oc_d;
    end
    if (cmd_i.out_load) begin
      out_data_q <= res_q;
      out_oc_q   <= res_oc_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_user_o  = out_oc_q;

endmodule

// ----- hw/rtl/time_ordered_note_store_core.sv -----
// channel   dir  tdata                                          tuser
// s_axis    in   bar,beat,tick,status,key,vel,instr,end_bar,    func
//                end_tick,entry_index (88 bits)
// m_axis    out  first_index,match_count,bar,beat,tick,status,  outcome
//                key,vel,instr (72 bits)
// one request at a time through a single-port-write table memory with registered read
// insert shifts up each stored entry that sorts after the new note, query scans every
// stored entry, read fetches one entry; a full table, empty span or bad index returns
// its outcome without visiting any entry; each visited entry costs a read and a compare
// reset empties the table at once through the entry count, no clearing pass
// a result waiting on m_axis holds the next request only at its final step
module time_ordered_note_store_core import tons_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [87:0] s_axis_tdata_i,  // bar,beat,tick,status_byte,note_key,velocity,
                                       // instrument,end_bar,end_tick,entry_index
  input  logic [1:0]  s_axis_tuser_i,  // func
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [71:0] m_axis_tdata_o,  // first_index,match_count,out_bar,out_beat,out_tick,
                                       // out_status,out_key,out_velocity,out_instrument
  output logic [1:0]  m_axis_tuser_o   // outcome
);

  cmd_t cmd;
  sts_t sts;

  tons_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .s_valid_i(s_axis_tvalid_i),
    .s_ready_o(s_axis_tready_o),
    .sts_i    (sts),
    .cmd_o    (cmd)
  );

  tons_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .req_data_i (s_axis_tdata_i),
    .req_func_i (s_axis_tuser_i),
    .out_valid_o(m_axis_tvalid_o),
    .out_ready_i(m_axis_tready_i),
    .out_data_o (m_axis_tdata_o),
    .out_user_o (m_axis_tuser_o)
  );

endmodule

// ----- hw/rtl/tons_checker.sv -----
module tons_checker import tons_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [71:0] m_axis_tdata_o,
  input logic [1:0]  m_axis_tuser_o
);

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result changed while stalled");

  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("request taken while busy");

  a_error_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o != OC_OK) |-> m_axis_tdata_o == '0)
    else $error("error result carries data");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[16:8] <= 9'(TableDepth))
    else $error("match count out of range");

  a_reset_idle: assert property (@(posedge clk_i)
    !rst_ni |-> !m_axis_tvalid_o)
    else $error("result valid in reset");

endmodule

bind time_ordered_note_store_core tons_checker u_tons_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .s_axis_tvalid_i(s_axis_tvalid_i),
  .s_axis_tready_o(s_axis_tready_o),
  .m_axis_tvalid_o(m_axis_tvalid_o),
  .m_axis_tready_i(m_axis_tready_i),
  .m_axis_tdata_o (m_axis_tdata_o),
  .m_axis_tuser_o (m_axis_tuser_o)
);

// ----- test/tb.sv -----
`timescale 1ns / 100ps

module tb;
  import tons_pkg::*;

  localparam int StallLimit = 20000;

  typedef struct {
    outcome_e    outcome;
    logic [7:0]  first_index;
    logic [8:0]  match_count;
    logic [8:0]  bar;
    logic [3:0]  beat;
    logic [15:0] tick;
    logic [7:0]  status;
    logic [6:0]  key;
    logic [6:0]  vel;
    logic [3:0]  instr;
  } note_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [87:0] s_axis_tdata_i;
  logic [1:0]  s_axis_tuser_i;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [71:0] m_axis_tdata_o;
  logic [1:0]  m_axis_tuser_o;

  time_ordered_note_store_core dut (.*);

  note_result_t expected_results[$];
  logic [8:0]  tbl_bar[TableDepth];
  logic [3:0]  tbl_beat[TableDepth];
  logic [15:0] tbl_tick[TableDepth];
  logic [7:0]  tbl_status[TableDepth];
  logic [6:0]  tbl_key[TableDepth];
  logic [6:0]  tbl_vel[TableDepth];
  logic [3:0]  tbl_instr[TableDepth];
  int          note_count;
  int          error_count;
  int          request_count;
  int          result_count;
  int          idle_cycles;
  bit          burst_mode;
  bit          stall_mode;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [24:0] time_key(logic [8:0] b, logic [15:0] t);
    return {b, t};
  endfunction

  function automatic int first_not_before(logic [24:0] k);
    int i;
    for (i = 0; i < note_count; i++)
      if (time_key(tbl_bar[i], tbl_tick[i]) >= k) break;
    return i;
  endfunction

  function automatic note_result_t predict_note_store(func_e fn, logic [87:0] d);
    note_result_t r;
    logic [8:0]  b;
    logic [15:0] t;
    logic [7:0]  st;
    logic [24:0] nk;
    logic [24:0] ek;
    int          pos;
    int          last;
    int          idx;
    r = '{outcome: OC_OK, default: '0};
    b = d[8:0];
    t = d[28:13];
    st = d[36:29];
    case (fn)
      FN_INSERT: begin
        if (note_count >= TableDepth) begin
          r.outcome = OC_FULL;
        end else begin
          nk = time_key(b, t);
          for (pos = 0; pos < note_count; pos++) begin
            ek = time_key(tbl_bar[pos], tbl_tick[pos]);
            if (ek > nk || (ek == nk && tbl_status[pos] <= st)) break;
          end
          for (int j = note_count; j > pos; j--) begin
            tbl_bar[j] = tbl_bar[j-1];
            tbl_beat[j] = tbl_beat[j-1];
            tbl_tick[j] = tbl_tick[j-1];
            tbl_status[j] = tbl_status[j-1];
            tbl_key[j] = tbl_key[j-1];
            tbl_vel[j] = tbl_vel[j-1];
            tbl_instr[j] = tbl_instr[j-1];
          end
          tbl_bar[pos] = b;
          tbl_beat[pos] = d[12:9];
          tbl_tick[pos] = t;
          tbl_status[pos] = st;
          tbl_key[pos] = d[43:37];
          tbl_vel[pos] = d[50:44];
          tbl_instr[pos] = d[54:51];
          note_count++;
        end
      end
      FN_QUERY: begin
        nk = time_key(b, t);
        ek = time_key(d[63:55], d[79:64]);
        pos = first_not_before(nk);
        last = first_not_before(ek);
        if (ek <= nk || last <= pos) begin
          r.outcome = OC_EMPTY;
        end else begin
          r.first_index = pos[7:0];
          r.match_count = 9'(last - pos);
        end
      end
      FN_READ: begin
        idx = int'(d[87:80]);
        if (idx >= note_count) begin
          r.outcome = OC_BAD_IDX;
        end else begin
          r.bar = tbl_bar[idx];
          r.beat = tbl_beat[idx];
          r.tick = tbl_tick[idx];
          r.status = tbl_status[idx];
          r.key = tbl_key[idx];
          r.vel = tbl_vel[idx];
          r.instr = tbl_instr[idx];
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch on result %0d: %s got %0h expected %0h", result_count, what, got, want);
    error_count++;
  endtask

  task automatic send_request(func_e fn, logic [87:0] d);
    if (burst_mode && $urandom_range(0, 7) == 0)
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    s_axis_tvalid_i = 1'b1;
    s_axis_tdata_i = d;
    s_axis_tuser_i = fn;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    expected_results.push_back(predict_note_store(fn, d));
    request_count++;
    @(negedge clk_i);
    s_axis_tvalid_i = 1'b0;
  endtask

  function automatic logic [87:0] note_data(logic [8:0] b, logic [15:0] t, logic [7:0] st);
    logic [87:0] d;
    d = 88'({$urandom, $urandom, $urandom});
    d[8:0] = b;
    d[28:13] = t;
    d[36:29] = st;
    return d;
  endfunction

  function automatic logic [87:0] query_data(logic [8:0] b, logic [15:0] t,
                                             logic [8:0] eb, logic [15:0] et);
    logic [87:0] d;
    d = note_data(b, t, 8'($urandom));
    d[63:55] = eb;
    d[79:64] = et;
    return d;
  endfunction

  function automatic logic [87:0] read_data(int idx);
    logic [87:0] d;
    d = 88'({$urandom, $urandom, $urandom});
    d[87:80] = idx[7:0];
    return d;
  endfunction

  task automatic wait_drained();
    while (expected_results.size() != 0) @(negedge clk_i);
  endtask

  task automatic test_directed();
    send_request(FN_READ, read_data(0));
    send_request(FN_QUERY, query_data(0, 0, 511, 16'hffff));
    send_request(FN_INSERT, note_data(5, 100, 8'h90));
    send_request(FN_INSERT, note_data(5, 100, 8'h80));
    send_request(FN_INSERT, note_data(5, 100, 8'h90));
    send_request(FN_INSERT, note_data(0, 0, 8'h00));
    send_request(FN_INSERT, note_data(511, 16'hffff, 8'hff));
    send_request(FN_INSERT, {88{1'b1}});
    send_request(FN_INSERT, 88'h0);
    send_request(FN_QUERY, query_data(5, 100, 5, 101));
    send_request(FN_QUERY, query_data(5, 100, 5, 100));
    send_request(FN_QUERY, query_data(6, 0, 5, 100));
    send_request(FN_QUERY, query_data(100, 0, 200, 0));
    send_request(FN_QUERY, query_data(0, 0, 511, 16'hffff));
    send_request(FN_NONE, {88{1'b1}});
    for (int i = 0; i < 8; i++) send_request(FN_READ, read_data(i));
    send_request(FN_READ, read_data(255));
    wait_drained();
  endtask

  task automatic test_random_mix(int n);
    int   f;
    logic [8:0] b;
    for (int i = 0; i < n; i++) begin
      if (note_count == TableDepth) break;
      f = $urandom_range(0, 9);
      b = $urandom_range(0, 3) == 0 ? 9'($urandom) : 9'($urandom_range(0, 7));
      if (f < 4) begin
        send_request(FN_INSERT, note_data(b, $urandom_range(0, 3) == 0 ? 16'($urandom)
                     : 16'($urandom_range(0, 4)), $urandom_range(0, 1) ? 8'h90 : 8'($urandom)));
      end else if (f < 7) begin
        send_request(FN_QUERY, query_data(b, 16'($urandom_range(0, 4)),
                     9'(b + $urandom_range(0, 2)),
                     $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 4))));
      end else if (f < 9) begin
        send_request(FN_READ, read_data($urandom_range(0, note_count)));
      end else begin
        send_request(FN_NONE, 88'({$urandom, $urandom, $urandom}));
      end
    end
  endtask

  task automatic test_full_table();
    while (note_count < TableDepth)
      send_request(FN_INSERT, note_data(9'($urandom), 16'($urandom), 8'($urandom)));
    send_request(FN_INSERT, note_data(0, 0, 0));
    send_request(FN_INSERT, {88{1'b1}});
    send_request(FN_QUERY, query_data(0, 0, 511, 16'hffff));
    send_request(FN_READ, read_data(255));
    send_request(FN_READ, read_data(0));
    for (int i = 0; i < 60; i++)
      send_request(FN_QUERY, query_data(9'($urandom), 16'($urandom), 9'($urandom),
                                        16'($urandom)));
    for (int i = 0; i < 300; i++)
      send_request(FN_READ, read_data($urandom_range(0, 255)));
  endtask

  always @(negedge clk_i) begin
    if (!rst_ni)
      m_axis_tready_i <= 1'b0;
    else if (stall_mode)
      m_axis_tready_i <= ($urandom_range(0, 3) != 0) && (($urandom_range(0, 31) != 0));
    else
      m_axis_tready_i <= 1'b1;
  end

  always @(posedge clk_i) begin
    note_result_t e;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (expected_results.size() == 0) begin
        $display("unexpected result %0d", result_count);
        error_count++;
      end else begin
        e = expected_results.pop_front();
        if (m_axis_tuser_o != e.outcome) report_mismatch("outcome", m_axis_tuser_o, e.outcome);
        if (m_axis_tdata_o[7:0] != e.first_index)
          report_mismatch("first_index", m_axis_tdata_o[7:0], e.first_index);
        if (m_axis_tdata_o[16:8] != e.match_count)
          report_mismatch("match_count", m_axis_tdata_o[16:8], e.match_count);
        if (m_axis_tdata_o[25:17] != e.bar) report_mismatch("bar", m_axis_tdata_o[25:17], e.bar);
        if (m_axis_tdata_o[29:26] != e.beat)
          report_mismatch("beat", m_axis_tdata_o[29:26], e.beat);
        if (m_axis_tdata_o[45:30] != e.tick)
          report_mismatch("tick", m_axis_tdata_o[45:30], e.tick);
        if (m_axis_tdata_o[53:46] != e.status)
          report_mismatch("status", m_axis_tdata_o[53:46], e.status);
        if (m_axis_tdata_o[60:54] != e.key) report_mismatch("key", m_axis_tdata_o[60:54], e.key);
        if (m_axis_tdata_o[67:61] != e.vel) report_mismatch("vel", m_axis_tdata_o[67:61], e.vel);
        if (m_axis_tdata_o[71:68] != e.instr)
          report_mismatch("instr", m_axis_tdata_o[71:68], e.instr);
      end
      result_count++;
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("timeout with %0d results pending", expected_results.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    rst_ni = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i = '0;
    s_axis_tuser_i = FN_INSERT;
    note_count = 0;
    error_count = 0;
    request_count = 0;
    result_count = 0;
    burst_mode = 1'b0;
    stall_mode = 1'b0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    burst_mode = 1'b1;
    stall_mode = 1'b1;
    test_random_mix(350);
    wait_drained();
    stall_mode = 1'b0;
    test_random_mix(150);
    burst_mode = 1'b0;
    stall_mode = 1'b1;
    test_full_table();
    wait_drained();
    repeat (40) @(negedge clk_i);
    $display("covered %0d requests and %0d results: inserts, range queries, reads,",
             request_count, result_count);
    $display("ignored codes, empty spans, bad indexes and a full table of %0d notes", note_count);
    if (error_count == 0 && expected_results.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
